@@ design/lru_key_tracker_with_eviction_defines.svh @@
// ----------------------------------------------------------------------------
// lru_key_tracker_with_eviction_defines
// Assertion macros shared by the recency tracker RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_TRACKER_WITH_EVICTION_DEFINES_SVH
`define LRU_KEY_TRACKER_WITH_EVICTION_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define LKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define LKT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ design/lkt_pkg.sv @@
// ----------------------------------------------------------------------------
// lkt_pkg
// Shared types and constants of the recency tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package lkt_pkg;

  localparam int KEY_W  = 32;
  localparam int CFG_W  = 32;
  localparam int MAXK_W = 5;

  localparam logic OP_ACCESS = 1'b0;
  localparam logic OP_FORGET = 1'b1;

  // Byte address of the max_keys register.
  localparam logic [1:0] ADDR_MAX_KEYS = 2'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD,
    ST_EVICT
  } state_t;

  typedef struct packed {
    logic latch;
    logic compare;
    logic update;
    logic evict;
  } ctrl_cmd_t;

  typedef struct packed {
    logic evict_needed;
    logic last_evict;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ design/lkt_ctrl.sv @@
// ----------------------------------------------------------------------------
// lkt_ctrl
// Sequencer of the recency tracker: compare, update, then one eviction a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lkt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire lkt_pkg::dp_sts_t   sts,
  output lkt_pkg::ctrl_cmd_t      cmd,
  output logic                    busy
);

  lkt_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lkt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lkt_pkg::ST_IDLE: begin
        if (start) state_nxt = lkt_pkg::ST_CMP;
      end
      lkt_pkg::ST_CMP: begin
        state_nxt = lkt_pkg::ST_UPD;
      end
      lkt_pkg::ST_UPD: begin
        state_nxt = sts.evict_needed ? lkt_pkg::ST_EVICT : lkt_pkg::ST_IDLE;
      end
      lkt_pkg::ST_EVICT: begin
        if (sts.last_evict) state_nxt = lkt_pkg::ST_IDLE;
      end
      default: state_nxt = lkt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state_r)
      lkt_pkg::ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      lkt_pkg::ST_CMP:   cmd.compare = 1'b1;
      lkt_pkg::ST_UPD:   cmd.update  = 1'b1;
      lkt_pkg::ST_EVICT: cmd.evict   = 1'b1;
      default: busy = 1'b0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/lkt_dp.sv @@
// ----------------------------------------------------------------------------
// lkt_dp
// Datapath of the recency tracker: key list, match, reorder and eviction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module lkt_dp #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire lkt_pkg::ctrl_cmd_t          cmd,
  output lkt_pkg::dp_sts_t                 sts,
  input  wire logic [lkt_pkg::MAXK_W-1:0]  max_keys,
  input  wire logic                        in_op,
  input  wire logic [lkt_pkg::KEY_W-1:0]   in_key_id,
  input  wire logic                        in_key_exists,
  output logic                             out_valid,
  output logic                             out_evict_valid,
  output logic [lkt_pkg::KEY_W-1:0]        out_evicted_key,
  output logic                             out_was_tracked,
  output logic                             out_last
);

  localparam int SKW = (KEY_BITS < lkt_pkg::KEY_W) ? KEY_BITS : lkt_pkg::KEY_W;
  localparam int CW  = $clog2(CAPACITY + 2);
  localparam int IW  = $clog2(CAPACITY);

  logic [SKW-1:0] keys_r [CAPACITY];
  logic [SKW-1:0] keys_nxt [CAPACITY];
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [SKW-1:0] spill_r, spill_nxt;
  logic           op_r, exists_r;
  logic [SKW-1:0] key_r;
  logic           was_r, was_nxt;
  logic [IW-1:0]  pos_r, pos_nxt;

  logic                      ov_r, ov_nxt;
  logic                      oev_r, oev_nxt;
  logic [lkt_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic                      olast_r, olast_nxt;

  logic          tracking, access;
  logic [CW-1:0] lim, new_cnt, cnt_dec;
  logic [SKW-1:0] tail_key;

  always_comb begin
    tracking = (max_keys != '0);
    access   = (op_r == lkt_pkg::OP_ACCESS) && exists_r;
    if (32'(max_keys) < CAPACITY) lim = CW'(max_keys);
    else lim = CW'(CAPACITY);
    new_cnt  = was_r ? cnt_r : cnt_r + CW'(1);
    cnt_dec  = cnt_r - CW'(1);
    tail_key = (cnt_r == CW'(CAPACITY + 1)) ? spill_r : keys_r[cnt_dec[IW-1:0]];
    sts.evict_needed = tracking && access && (new_cnt > lim);
    sts.last_evict   = (cnt_dec == lim);
  end

  // Parallel match against the occupied entries and a one-hot to index encode.
  always_comb begin
    was_nxt = 1'b0;
    pos_nxt = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if ((CW'(i) < cnt_r) && (keys_r[i] == key_r)) begin
        was_nxt = 1'b1;
        pos_nxt = pos_nxt | IW'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) keys_nxt[i] = keys_r[i];
    cnt_nxt   = cnt_r;
    spill_nxt = spill_r;
    ov_nxt    = 1'b0;
    oev_nxt   = 1'b0;
    okey_nxt  = '0;
    olast_nxt = 1'b1;
    if (cmd.update) begin
      if (tracking && access) begin
        // Entries before the old position (all entries for a new key) move back by one; the new key goes in front.
        keys_nxt[0] = key_r;
        for (int i = 1; i < CAPACITY; i++) begin
          if (!was_r || ((IW + 1)'(i) <= {1'b0, pos_r})) keys_nxt[i] = keys_r[i - 1];
        end
        spill_nxt = keys_r[CAPACITY - 1];
        cnt_nxt   = new_cnt;
      end else if (tracking && was_r) begin
        for (int i = 0; i < CAPACITY - 1; i++) begin
          if ((IW + 1)'(i) >= {1'b0, pos_r}) keys_nxt[i] = keys_r[i + 1];
        end
        cnt_nxt = cnt_dec;
      end
      ov_nxt = !sts.evict_needed;
    end else if (cmd.evict) begin
      ov_nxt    = 1'b1;
      oev_nxt   = 1'b1;
      okey_nxt  = lkt_pkg::KEY_W'(tail_key);
      olast_nxt = sts.last_evict;
      cnt_nxt   = cnt_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) keys_r[i] <= keys_nxt[i];
    spill_r <= spill_nxt;
    oev_r   <= oev_nxt;
    okey_r  <= okey_nxt;
    olast_r <= olast_nxt;
    if (cmd.latch) begin
      op_r     <= in_op;
      key_r    <= in_key_id[SKW-1:0];
      exists_r <= in_key_exists;
    end
    if (cmd.compare) begin
      was_r <= was_nxt;
      pos_r <= pos_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_evict_valid = oev_r;
  assign out_evicted_key = okey_r;
  assign out_was_tracked = was_r;
  assign out_last        = olast_r;

endmodule
`default_nettype wire

@@ design/lru_key_tracker_with_eviction.sv @@
// ----------------------------------------------------------------------------
// lru_key_tracker_with_eviction
// Recency list of key identifiers with eviction down to a programmable cap.
// ----------------------------------------------------------------------------
// A command is transferred when start is high and busy is low. op 0 records
// an access (moved or inserted at the newest place if the key exists, dropped
// otherwise); op 1 forgets the key. The block then reports each evicted key,
// oldest first, one per cycle on out_valid; a command without eviction gives a
// single result with out_evict_valid low. out_last marks the final result.
// The transfer latches the command; the compare state then registers the
// parallel key match and the update state updates the list. Without eviction
// the update state also loads the output register with the single result.
// Otherwise the eviction state pops the tail of the list once a cycle, each
// pop presenting one eviction. busy falls in the cycle that presents the last
// result. The receiver cannot stall: each result is valid for one cycle only.
// max_keys is written by any APB write (read back as register 0); the user
// must write it only while busy is low; the block itself does not enforce
// it. Zero turns tracking off. Synchronous reset empties the list and
// clears max_keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "lru_key_tracker_with_eviction_defines.svh"
module lru_key_tracker_with_eviction #(
  parameter int CAPACITY = 16,
  parameter int KEY_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        in_op,
  input  wire logic [lkt_pkg::KEY_W-1:0]   in_key_id,
  input  wire logic                        in_key_exists,
  output logic                             out_valid,
  output logic                             out_evict_valid,
  output logic [lkt_pkg::KEY_W-1:0]        out_evicted_key,
  output logic                             out_was_tracked,
  output logic                             out_last,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [1:0]                  paddr,
  input  wire logic [lkt_pkg::CFG_W-1:0]   pwdata,
  output logic [lkt_pkg::CFG_W-1:0]        prdata,
  output logic                             pready
);

  logic [lkt_pkg::MAXK_W-1:0] max_keys_r;
  lkt_pkg::ctrl_cmd_t cmd;
  lkt_pkg::dp_sts_t   sts;

  assign pready = 1'b1;
  assign prdata = (paddr == lkt_pkg::ADDR_MAX_KEYS) ? lkt_pkg::CFG_W'(max_keys_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_keys_r <= '0;
    end else if (psel && penable && pwrite && pready) begin
      max_keys_r <= pwdata[lkt_pkg::MAXK_W-1:0];
    end
  end

  lkt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  lkt_dp #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .max_keys        (max_keys_r),
    .in_op           (in_op),
    .in_key_id       (in_key_id),
    .in_key_exists   (in_key_exists),
    .out_valid       (out_valid),
    .out_evict_valid (out_evict_valid),
    .out_evicted_key (out_evicted_key),
    .out_was_tracked (out_was_tracked),
    .out_last        (out_last)
  );

  `LKT_ASSERT_IMP(a_noevict_last, out_valid && !out_evict_valid, out_last, "lone result not last")
  `LKT_ASSERT_NXT(a_start_busy, start && !busy, busy, "transfer did not raise busy")
  `LKT_ASSERT_NXT(a_last_gap, out_valid && out_last, !out_valid, "result after last")
  `LKT_ASSERT_IMP(a_not_last_busy, out_valid && !out_last, busy, "idle between results")

endmodule
`default_nettype wire

@@ bench/tb_lru_key_tracker_with_eviction.sv @@
// ----------------------------------------------------------------------------
// tb_lru_key_tracker_with_eviction
// Self-checking bench for the key recency tracker with eviction.
// ----------------------------------------------------------------------------
// A directed table covers tracking off, small caps, dropped and forgotten keys
// and the extreme key values. Random phases then run through several caps,
// including the largest register value and a sharp cap reduction. Every
// command is predicted by a recency list kept in the bench, and each result
// transfer is compared field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_lru_key_tracker_with_eviction;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic                       evict_valid;
    logic [lkt_pkg::KEY_W-1:0]  evicted_key;
    logic                       was_tracked;
    logic                       last;
  } evict_res_t;

  typedef struct {
    bit                         is_cfg;
    logic [lkt_pkg::CFG_W-1:0]  cfg_val;
    logic                       op;
    logic [lkt_pkg::KEY_W-1:0]  key;
    logic                       exists;
    bit                         typed;
    evict_res_t                 res;
  } cmd_row_t;

  logic clk, rst_n, start, busy;
  logic in_op, in_key_exists;
  logic [lkt_pkg::KEY_W-1:0] in_key_id;
  logic out_valid, out_evict_valid, out_was_tracked, out_last;
  logic [lkt_pkg::KEY_W-1:0] out_evicted_key;
  logic psel, penable, pwrite, pready;
  logic [1:0] paddr;
  logic [lkt_pkg::CFG_W-1:0] pwdata, prdata;

  logic [lkt_pkg::KEY_W-1:0] recency_list[$];   // newest first
  int unsigned               cap_reg;
  evict_res_t                pending_res[$];
  cmd_row_t                  cmd_table[$];
  logic [lkt_pkg::KEY_W-1:0] key_pool[24];
  int                        errors = 0;
  int                        idle_pct;
  longint                    cycles = 0;

  lru_key_tracker_with_eviction uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_op(in_op), .in_key_id(in_key_id), .in_key_exists(in_key_exists),
    .out_valid(out_valid), .out_evict_valid(out_evict_valid),
    .out_evicted_key(out_evicted_key), .out_was_tracked(out_was_tracked),
    .out_last(out_last), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Work out the results of one command and update the bench's recency list.
  function automatic void predict_evictions(logic op, logic [lkt_pkg::KEY_W-1:0] key,
                                            logic exists);
    int pos;
    int limit;
    int first;
    evict_res_t r;
    pos = -1;
    first = pending_res.size();
    foreach (recency_list[i]) if (pos < 0 && recency_list[i] == key) pos = i;
    if (cap_reg != 0) begin
      if (op == lkt_pkg::OP_FORGET || !exists) begin
        if (pos >= 0) recency_list.delete(pos);
      end else begin
        if (pos >= 0) recency_list.delete(pos);
        recency_list.push_front(key);
        limit = (cap_reg < DEPTH) ? cap_reg : DEPTH;
        while (recency_list.size() > limit) begin
          r.evict_valid = 1'b1;
          r.evicted_key = recency_list.pop_back();
          r.was_tracked = (pos >= 0);
          r.last = 1'b0;
          pending_res.insert(pending_res.size(), r);
        end
      end
    end
    if (pending_res.size() == first) begin
      r.evict_valid = 1'b0;
      r.evicted_key = '0;
      r.was_tracked = (pos >= 0);
      r.last = 1'b0;
      pending_res.insert(pending_res.size(), r);
    end
    pending_res[pending_res.size()-1].last = 1'b1;
  endfunction

  // Holds start high (it is never lowered while a further command follows at once).
  task automatic issue_cmd(logic op, logic [lkt_pkg::KEY_W-1:0] key, logic exists,
                           bit typed, evict_res_t res);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct) gap++;
    if (gap > 0 && start) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_key_id <= key;
    in_key_exists <= exists;
    do @(posedge clk); while (busy);
    predict_evictions(op, key, exists);
    if (typed) pending_res[pending_res.size()-1] = res;
  endtask

  task automatic write_cap(logic [lkt_pkg::CFG_W-1:0] val);
    if (start) begin
      start <= 1'b0;
      @(posedge clk);
    end
    while (pending_res.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= lkt_pkg::ADDR_MAX_KEYS;
    pwdata <= val;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    cap_reg = val[lkt_pkg::MAXK_W-1:0];
  endtask

  function automatic void add_cmd(logic op, logic [lkt_pkg::KEY_W-1:0] key, logic exists,
                                  bit typed = 0, logic ev = 0,
                                  logic [lkt_pkg::KEY_W-1:0] ek = '0, logic was = 0);
    cmd_row_t row;
    row.is_cfg = 0;
    row.cfg_val = '0;
    row.op = op;
    row.key = key;
    row.exists = exists;
    row.typed = typed;
    row.res.evict_valid = ev;
    row.res.evicted_key = ek;
    row.res.was_tracked = was;
    row.res.last = 1'b1;
    cmd_table.insert(cmd_table.size(), row);
  endfunction

  function automatic void add_cfg(logic [lkt_pkg::CFG_W-1:0] val);
    cmd_row_t row;
    row = '{default: '0};
    row.is_cfg = 1;
    row.cfg_val = val;
    cmd_table.insert(cmd_table.size(), row);
  endfunction

  // Result transfers cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk) begin
    evict_res_t e;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $error("unexpected result: evicted_key %h", out_evicted_key);
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (out_evict_valid !== e.evict_valid) begin
          $error("evict_valid: expected %b, got %b", e.evict_valid, out_evict_valid);
          errors++;
        end
        if (out_evicted_key !== e.evicted_key) begin
          $error("evicted_key: expected %h, got %h", e.evicted_key, out_evicted_key);
          errors++;
        end
        if (out_was_tracked !== e.was_tracked) begin
          $error("was_tracked: expected %b, got %b", e.was_tracked, out_was_tracked);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %b, got %b", e.last, out_last);
          errors++;
        end
      end
    end
  end

  initial begin
    int caps[6];
    int unsigned idx;
    evict_res_t none;
    logic [lkt_pkg::KEY_W-1:0] k;
    cap_reg = 0;
    idle_pct = 6;
    none = '{default: '0};
    rst_n = 1'b0;
    start = 1'b0;
    in_op = lkt_pkg::OP_ACCESS;
    in_key_id = '0;
    in_key_exists = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Tracking off after reset, then a cap of two with the extreme keys.
    add_cmd(lkt_pkg::OP_ACCESS, 32'h0, 1'b1, 1, 0, 0, 0);
    add_cmd(lkt_pkg::OP_FORGET, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 0);
    add_cfg(2);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h0, 1'b1, 1, 0, 0, 0);
    add_cmd(lkt_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 0);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h1, 1'b1, 1, 1, 32'h0, 0);
    add_cmd(lkt_pkg::OP_ACCESS, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h1, 1'b0, 1, 0, 0, 1);
    add_cmd(lkt_pkg::OP_FORGET, 32'h1, 1'b0, 1, 0, 0, 0);
    add_cmd(lkt_pkg::OP_FORGET, 32'hFFFF_FFFF, 1'b1, 1, 0, 0, 1);
    add_cfg(3);
    add_cmd(lkt_pkg::OP_ACCESS, 32'hA5A5_A5A5, 1'b1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h5A5A_5A5A, 1'b1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h8000_0000, 1'b1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'hA5A5_A5A5, 1'b1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h0000_0001, 1'b1);
    add_cmd(lkt_pkg::OP_FORGET, 32'h5A5A_5A5A, 1'b0);
    // Turning tracking off keeps the list; was_tracked still sees old entries.
    add_cfg(0);
    add_cmd(lkt_pkg::OP_ACCESS, 32'hA5A5_A5A5, 1'b1);
    add_cmd(lkt_pkg::OP_FORGET, 32'h0000_0001, 1'b1);
    add_cmd(lkt_pkg::OP_ACCESS, 32'h1234_5678, 1'b1);

    foreach (cmd_table[i]) begin
      if (cmd_table[i].is_cfg) write_cap(cmd_table[i].cfg_val);
      else issue_cmd(cmd_table[i].op, cmd_table[i].key, cmd_table[i].exists,
                     cmd_table[i].typed, cmd_table[i].res);
    end

    foreach (key_pool[i]) key_pool[i] = $urandom();
    key_pool[0] = 32'h0;
    key_pool[1] = 32'hFFFF_FFFF;
    // The full list under the largest cap is cut to one in a single command.
    caps = '{31, 1, 7, 0, 16, 3};
    for (int ph = 0; ph < 6; ph++) begin
      write_cap(caps[ph]);
      idle_pct = (ph < 2) ? 6 : (ph < 4) ? 49 : 0;
      for (int n = 0; n < 68; n++) begin
        idx = $urandom_range(23);
        k = ($urandom_range(19) == 0) ? $urandom() : key_pool[idx];
        issue_cmd(($urandom_range(99) < 15) ? lkt_pkg::OP_FORGET : lkt_pkg::OP_ACCESS, k,
                  ($urandom_range(99) < 85), 0, none);
      end
    end

    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (errors == 0 && pending_res.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
